/* rtl/core/rssc_pkg.sv */
// ----------------------------------------------------------------------------
// rssc_pkg: shared types for the raster seed scan controller
// Beat layouts of the tick channel and the result channel.
// ----------------------------------------------------------------------------
package rssc_pkg;

  localparam int FIELD_W = 8;

  typedef struct packed {
    logic toggle_run;
    logic pixel_ready;
    logic pixel_set;
    logic visited_ready;
    logic visited_mark;
    logic labeler_done;
  } tick_t;

  typedef struct packed {
    logic [FIELD_W-1:0] scan_row;
    logic [FIELD_W-1:0] scan_col;
    logic               pixel_read_req;
    logic               visited_read_req;
    logic               visited_write_req;
    logic               visited_write_value;
    logic               labeler_start;
    logic [FIELD_W-1:0] seed_row;
    logic [FIELD_W-1:0] seed_col;
    logic               scan_finished;
    logic               running;
  } result_t;

endpackage

/* rtl/core/rssc_in_reg.sv */
// ----------------------------------------------------------------------------
// rssc_in_reg: input register of the tick channel
// Holds one tick beat until the core consumes it.
// ----------------------------------------------------------------------------
module rssc_in_reg
  import rssc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  tick_t in_tick,
  input  logic  consume,
  output logic  held_valid,
  output tick_t held_tick
);

  assign in_stall = held_valid && !consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!in_stall) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      held_tick <= in_tick;
    end
  end

endmodule

/* rtl/core/rssc_core.sv */
// ----------------------------------------------------------------------------
// rssc_core: scan state and per-tick update
// Raster walk, seed hand-off, mark writes and run flag, one tick per step.
// ----------------------------------------------------------------------------
module rssc_core
  import rssc_pkg::*;
#(
  parameter int IMAGE_ROWS = 256,
  parameter int IMAGE_COLS = 256,
  parameter int COORD_BITS = 8
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    step,
  input  tick_t   tick,
  output result_t result_next
);

  logic                  run_flag, run_flag_next;
  logic                  wait_labeler, wait_labeler_next;
  logic [COORD_BITS-1:0] row_count, row_count_next;
  logic [COORD_BITS-1:0] col_count, col_count_next;
  logic                  pixel_req_flag, pixel_req_flag_next;
  logic                  visited_req_flag, visited_req_flag_next;
  logic                  mark_write_flag, mark_write_flag_next;
  logic                  mark_write_bit, mark_write_bit_next;
  logic                  done_flag, done_flag_next;
  logic                  labeler_go, labeler_go_next;
  logic [COORD_BITS-1:0] seed_row_reg, seed_row_reg_next;
  logic [COORD_BITS-1:0] seed_col_reg, seed_col_reg_next;

  logic [COORD_BITS:0]   row_inc, col_inc;
  logic                  at_last, at_eol;

  assign row_inc = {1'b0, row_count} + 1'b1;
  assign col_inc = {1'b0, col_count} + 1'b1;
  // compares in 32 bits: the image may be larger than the coordinate range
  assign at_eol  = (32'(col_inc) == 32'(IMAGE_COLS));
  assign at_last = at_eol && (32'(row_inc) == 32'(IMAGE_ROWS));

  always_comb begin
    logic do_adv;
    do_adv                = 1'b0;
    wait_labeler_next     = wait_labeler;
    row_count_next        = row_count;
    col_count_next        = col_count;
    pixel_req_flag_next   = pixel_req_flag;
    visited_req_flag_next = visited_req_flag;
    mark_write_flag_next  = mark_write_flag;
    mark_write_bit_next   = mark_write_bit;
    done_flag_next        = 1'b0;
    labeler_go_next       = labeler_go;
    seed_row_reg_next     = seed_row_reg;
    seed_col_reg_next     = seed_col_reg;

    priority if (wait_labeler) begin
      if (tick.labeler_done) begin
        labeler_go_next   = 1'b0;
        wait_labeler_next = 1'b0;
        do_adv            = 1'b1;
      end
    end else if (run_flag && mark_write_flag && !pixel_req_flag && !done_flag) begin
      do_adv = 1'b1;
    end else if (run_flag && !mark_write_flag && !done_flag && pixel_req_flag
                 && tick.pixel_ready && tick.visited_ready) begin
      if (!tick.visited_mark) begin
        pixel_req_flag_next   = 1'b0;
        visited_req_flag_next = 1'b0;
        if (tick.pixel_set) begin
          seed_row_reg_next = row_count;
          seed_col_reg_next = col_count;
          wait_labeler_next = 1'b1;
          labeler_go_next   = 1'b1;
        end else begin
          mark_write_bit_next  = 1'b1;
          mark_write_flag_next = 1'b1;
        end
      end else begin
        do_adv = 1'b1;
      end
    end else if (run_flag && !pixel_req_flag && !visited_req_flag && !mark_write_flag) begin
      // fresh start from the top-left corner
      wait_labeler_next     = 1'b0;
      row_count_next        = '0;
      col_count_next        = '0;
      pixel_req_flag_next   = 1'b1;
      visited_req_flag_next = 1'b1;
    end else begin
    end

    if (do_adv) begin
      mark_write_flag_next = 1'b0;
      if (at_last) begin
        pixel_req_flag_next   = 1'b0;
        visited_req_flag_next = 1'b0;
        done_flag_next        = 1'b1;
      end else begin
        if (at_eol) begin
          row_count_next = row_inc[COORD_BITS-1:0];
          col_count_next = '0;
        end else begin
          col_count_next = col_inc[COORD_BITS-1:0];
        end
        pixel_req_flag_next   = 1'b1;
        visited_req_flag_next = 1'b1;
      end
    end

    run_flag_next = done_flag_next ? 1'b0 : (run_flag ^ tick.toggle_run);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_flag         <= 1'b0;
      wait_labeler     <= 1'b0;
      row_count        <= '0;
      col_count        <= '0;
      pixel_req_flag   <= 1'b0;
      visited_req_flag <= 1'b0;
      mark_write_flag  <= 1'b0;
      mark_write_bit   <= 1'b0;
      done_flag        <= 1'b0;
      labeler_go       <= 1'b0;
      seed_row_reg     <= '0;
      seed_col_reg     <= '0;
    end else if (step) begin
      run_flag         <= run_flag_next;
      wait_labeler     <= wait_labeler_next;
      row_count        <= row_count_next;
      col_count        <= col_count_next;
      pixel_req_flag   <= pixel_req_flag_next;
      visited_req_flag <= visited_req_flag_next;
      mark_write_flag  <= mark_write_flag_next;
      mark_write_bit   <= mark_write_bit_next;
      done_flag        <= done_flag_next;
      labeler_go       <= labeler_go_next;
      seed_row_reg     <= seed_row_reg_next;
      seed_col_reg     <= seed_col_reg_next;
    end
  end

  always_comb begin
    result_next.scan_row            = FIELD_W'(row_count_next);
    result_next.scan_col            = FIELD_W'(col_count_next);
    result_next.pixel_read_req      = pixel_req_flag_next;
    result_next.visited_read_req    = visited_req_flag_next;
    result_next.visited_write_req   = mark_write_flag_next;
    result_next.visited_write_value = mark_write_bit_next;
    result_next.labeler_start       = labeler_go_next;
    result_next.seed_row            = FIELD_W'(seed_row_reg_next);
    result_next.seed_col            = FIELD_W'(seed_col_reg_next);
    result_next.scan_finished       = done_flag_next;
    result_next.running             = run_flag_next;
  end

endmodule

/* rtl/core/rssc_out_reg.sv */
// ----------------------------------------------------------------------------
// rssc_out_reg: result register of the output channel
// Loads a result beat when the core steps; holds it while stalled.
// ----------------------------------------------------------------------------
module rssc_out_reg
  import rssc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    held_valid,
  input  result_t result_next,
  output logic    step,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t result
);

  assign step = held_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result <= result_next;
    end
  end

endmodule

/* rtl/core/raster_seed_scan_controller.sv */
// ----------------------------------------------------------------------------
// raster_seed_scan_controller: raster scan that seeds a region labeler
// Each tick beat carries the store and labeler handshake bits of one clock
// of the surrounding system; each result beat carries the registered
// addresses, requests, seed coordinates and status after that tick.
// Channels: tick (in_valid/in_stall) and result (out_valid/out_stall); a
// beat moves on an edge with valid high and stall low.
// Every tick beat yields exactly one result beat. A beat is captured in the
// input register and then stepped into the result register, from which its
// result is offered. One beat a cycle is sustained while the result channel
// is not stalled; the single step of the scan state per beat sets that rate.
// Stalling the result channel holds the result register; the input
// register then fills and in_stall rises, with the scan state frozen.
// Reset clears the run flag, coordinates, requests and seed, and empties
// both registers.
// ----------------------------------------------------------------------------
module raster_seed_scan_controller
  import rssc_pkg::*;
#(
  parameter int IMAGE_ROWS = 256,
  parameter int IMAGE_COLS = 256,
  parameter int COORD_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               toggle_run,
  input  logic               pixel_ready,
  input  logic               pixel_set,
  input  logic               visited_ready,
  input  logic               visited_mark,
  input  logic               labeler_done,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [FIELD_W-1:0] scan_row,
  output logic [FIELD_W-1:0] scan_col,
  output logic               pixel_read_req,
  output logic               visited_read_req,
  output logic               visited_write_req,
  output logic               visited_write_value,
  output logic               labeler_start,
  output logic [FIELD_W-1:0] seed_row,
  output logic [FIELD_W-1:0] seed_col,
  output logic               scan_finished,
  output logic               running
);

  tick_t   in_tick, held_tick;
  logic    held_valid, step;
  result_t result_next, result;

  assign in_tick.toggle_run    = toggle_run;
  assign in_tick.pixel_ready   = pixel_ready;
  assign in_tick.pixel_set     = pixel_set;
  assign in_tick.visited_ready = visited_ready;
  assign in_tick.visited_mark  = visited_mark;
  assign in_tick.labeler_done  = labeler_done;

  rssc_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_tick    (in_tick),
    .consume    (step),
    .held_valid (held_valid),
    .held_tick  (held_tick)
  );

  rssc_core #(
    .IMAGE_ROWS (IMAGE_ROWS),
    .IMAGE_COLS (IMAGE_COLS),
    .COORD_BITS (COORD_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .tick        (held_tick),
    .result_next (result_next)
  );

  rssc_out_reg u_out_reg (
    .clk         (clk),
    .rst         (rst),
    .held_valid  (held_valid),
    .result_next (result_next),
    .step        (step),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result      (result)
  );

  assign scan_row            = result.scan_row;
  assign scan_col            = result.scan_col;
  assign pixel_read_req      = result.pixel_read_req;
  assign visited_read_req    = result.visited_read_req;
  assign visited_write_req   = result.visited_write_req;
  assign visited_write_value = result.visited_write_value;
  assign labeler_start       = result.labeler_start;
  assign seed_row            = result.seed_row;
  assign seed_col            = result.seed_col;
  assign scan_finished       = result.scan_finished;
  assign running             = result.running;

endmodule
